// File: rtl/core/uvd_pkg.sv
`timescale 1ns / 1ps

package uvd_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD  = 3'd0,
    MODE_INS_TAIL  = 3'd1,
    MODE_REM_HEAD  = 3'd2,
    MODE_REM_TAIL  = 3'd3,
    MODE_REM_VALUE = 3'd4,
    MODE_SEARCH    = 3'd5,
    MODE_READ_OUT  = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Which list position the memory read port addresses.
  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_NEXT  = 2'd1,
    RD_NEXT2 = 2'd2,
    RD_LAST  = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_HEAD = 2'd0,
    WR_TAIL = 2'd1,
    WR_POS  = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    EL_ZERO  = 2'd0,
    EL_RDATA = 2'd1,
    EL_SAVED = 2'd2
  } elem_sel_e;

  typedef struct packed {
    logic      load;
    logic      pos_clr;
    logic      pos_inc;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      head_inc;
    logic      head_dec;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      elem_cap;
    logic      emit;
    status_e   status;
    elem_sel_e elem_sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic pos_end;
  } dp_stat_t;

endpackage

// File: rtl/core/uvd_ctrl.sv
`timescale 1ns / 1ps

module uvd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [uvd_pkg::MODE_W-1:0]        mode_i,
  output logic                              busy_o,
  input  uvd_pkg::dp_stat_t                 stat_i,
  output uvd_pkg::dp_cmd_t                  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]     state_q, state_d;
  uvd_pkg::mode_e mode_q, mode_d;
  uvd_pkg::mode_e mode_in;

  assign mode_in = uvd_pkg::mode_e'(mode_i);
  assign busy_o  = (state_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = uvd_pkg::RD_FIRST;
    cmd_o.wr_sel   = uvd_pkg::WR_POS;
    cmd_o.status   = uvd_pkg::ST_OK;
    cmd_o.elem_sel = uvd_pkg::EL_ZERO;
    state_d        = state_q;
    mode_d         = mode_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          mode_d     = mode_in;
          case (mode_in)
            uvd_pkg::MODE_INS_HEAD, uvd_pkg::MODE_INS_TAIL: begin
              if (stat_i.cnt_zero) begin
                state_d = S_INSERT;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.pos_clr = 1'b1;
                state_d       = S_SCAN;
              end
            end
            uvd_pkg::MODE_REM_VALUE, uvd_pkg::MODE_SEARCH: begin
              if (stat_i.cnt_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.last   = 1'b1;
                cmd_o.status = uvd_pkg::ST_NOTFOUND;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.pos_clr = 1'b1;
                state_d       = S_SCAN;
              end
            end
            uvd_pkg::MODE_REM_HEAD, uvd_pkg::MODE_REM_TAIL: begin
              if (stat_i.cnt_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.last   = 1'b1;
                cmd_o.status = uvd_pkg::ST_EMPTY;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = (mode_in == uvd_pkg::MODE_REM_HEAD) ?
                               uvd_pkg::RD_FIRST : uvd_pkg::RD_LAST;
                state_d      = S_POP;
              end
            end
            uvd_pkg::MODE_READ_OUT: begin
              if (stat_i.cnt_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.last   = 1'b1;
                cmd_o.status = uvd_pkg::ST_EMPTY;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.pos_clr = 1'b1;
                state_d       = S_READ;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // The read of the next position is always issued; on a match it
        // already fetches the first element that the gap close moves.
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = uvd_pkg::RD_NEXT;
        if (stat_i.match) begin
          case (mode_q)
            uvd_pkg::MODE_INS_HEAD, uvd_pkg::MODE_INS_TAIL: begin
              cmd_o.emit   = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = uvd_pkg::ST_DUP;
              state_d      = S_IDLE;
            end
            uvd_pkg::MODE_REM_VALUE: begin
              cmd_o.elem_cap = 1'b1;
              state_d        = S_SHIFT;
            end
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              state_d    = S_IDLE;
            end
          endcase
        end else if (stat_i.pos_end) begin
          case (mode_q)
            uvd_pkg::MODE_INS_HEAD, uvd_pkg::MODE_INS_TAIL: begin
              if (stat_i.cnt_full) begin
                cmd_o.emit   = 1'b1;
                cmd_o.last   = 1'b1;
                cmd_o.status = uvd_pkg::ST_FULL;
                state_d      = S_IDLE;
              end else begin
                state_d = S_INSERT;
              end
            end
            default: begin
              cmd_o.emit   = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = uvd_pkg::ST_NOTFOUND;
              state_d      = S_IDLE;
            end
          endcase
        end else begin
          cmd_o.pos_inc = 1'b1;
        end
      end
      S_INSERT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.last     = 1'b1;
        cmd_o.head_dec = (mode_q == uvd_pkg::MODE_INS_HEAD);
        cmd_o.wr_sel   = (mode_q == uvd_pkg::MODE_INS_HEAD) ?
                         uvd_pkg::WR_HEAD : uvd_pkg::WR_TAIL;
        state_d        = S_IDLE;
      end
      S_POP: begin
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.head_inc = (mode_q == uvd_pkg::MODE_REM_HEAD);
        cmd_o.emit     = 1'b1;
        cmd_o.last     = 1'b1;
        cmd_o.elem_sel = uvd_pkg::EL_RDATA;
        state_d        = S_IDLE;
      end
      S_SHIFT: begin
        if (!stat_i.pos_end) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = uvd_pkg::WR_POS;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = uvd_pkg::RD_NEXT2;
          cmd_o.pos_inc = 1'b1;
        end else begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.elem_sel = uvd_pkg::EL_SAVED;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.emit     = 1'b1;
        cmd_o.elem_sel = uvd_pkg::EL_RDATA;
        cmd_o.last     = stat_i.pos_end;
        if (stat_i.pos_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = uvd_pkg::RD_NEXT;
          cmd_o.pos_inc = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= uvd_pkg::MODE_INS_HEAD;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  a_last_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("final beat did not return the controller to idle");

  a_shift_only_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (mode_q == uvd_pkg::MODE_REM_VALUE))
    else $error("gap close entered outside remove by value");

endmodule

// File: rtl/core/uvd_dp.sv
`timescale 1ns / 1ps

module uvd_dp #(
  parameter int unsigned CAPACITY = uvd_pkg::CAPACITY_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [uvd_pkg::VALUE_W-1:0]    value_i,
  input  uvd_pkg::dp_cmd_t                      cmd_i,
  output uvd_pkg::dp_stat_t                     stat_o,
  output logic                                  result_valid_o,
  output logic [uvd_pkg::STATUS_W-1:0]          status_o,
  output logic signed [uvd_pkg::VALUE_W-1:0]    element_o,
  output logic [uvd_pkg::COUNT_W-1:0]           count_o,
  output logic                                  last_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  logic [uvd_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [uvd_pkg::VALUE_W-1:0]        value_q;
  logic [uvd_pkg::VALUE_W-1:0]        rdata_q;
  logic [uvd_pkg::VALUE_W-1:0]        elem_q;
  logic [CNT_W-1:0]                   pos_q, pos_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic [IDX_W-1:0]                   head_q, head_d;
  logic [IDX_W-1:0]                   head_m1, head_p1;
  logic [CNT_W-1:0]                   rd_pos;
  logic [IDX_W-1:0]                   raddr, waddr;
  logic [uvd_pkg::VALUE_W-1:0]        wdata;
  logic [uvd_pkg::VALUE_W-1:0]        elem_out;
  logic                               out_valid_q;
  logic [uvd_pkg::STATUS_W-1:0]       out_status_q;
  logic signed [uvd_pkg::VALUE_W-1:0] out_elem_q;
  logic [uvd_pkg::COUNT_W-1:0]        out_count_q;
  logic                               out_last_q;

  // Physical slot of a list position; the sum stays below twice the depth.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign head_m1 = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
  assign head_p1 = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      uvd_pkg::RD_FIRST: rd_pos = '0;
      uvd_pkg::RD_NEXT:  rd_pos = pos_q + CNT_W'(1);
      uvd_pkg::RD_NEXT2: rd_pos = pos_q + CNT_W'(2);
      uvd_pkg::RD_LAST:  rd_pos = cnt_q - CNT_W'(1);
      default:           rd_pos = '0;
    endcase
  end

  assign raddr = slot_of(head_q, rd_pos);

  always_comb begin
    case (cmd_i.wr_sel)
      uvd_pkg::WR_HEAD: waddr = head_m1;
      uvd_pkg::WR_TAIL: waddr = slot_of(head_q, cnt_q);
      default:          waddr = slot_of(head_q, pos_q);
    endcase
  end

  // The gap close moves read data down one slot; inserts store the operand.
  assign wdata = (cmd_i.wr_sel == uvd_pkg::WR_POS) ? rdata_q : value_q;

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_clr) begin
      pos_d = '0;
    end else if (cmd_i.pos_inc) begin
      pos_d = pos_q + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = head_m1;
    end else if (cmd_i.head_inc) begin
      head_d = head_p1;
    end
  end

  always_comb begin
    case (cmd_i.elem_sel)
      uvd_pkg::EL_RDATA: elem_out = rdata_q;
      uvd_pkg::EL_SAVED: elem_out = elem_q;
      default:           elem_out = '0;
    endcase
  end

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.cnt_full = (cnt_q == CNT_W'(CAPACITY));
  assign stat_o.match    = (rdata_q == value_q);
  assign stat_o.pos_end  = ({1'b0, pos_q} + (CNT_W + 1)'(1)) >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
    if (cmd_i.elem_cap) begin
      elem_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_elem_q   <= elem_out;
      out_count_q  <= uvd_pkg::COUNT_W'(cnt_d);
      out_last_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      out_valid_q <= cmd_i.emit;
    end
  end

  assign result_valid_o = out_valid_q;
  assign status_o       = out_status_q;
  assign element_o      = out_elem_q;
  assign count_o        = out_count_q;
  assign last_o         = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IDX_W'(CAPACITY - 1))
    else $error("head slot outside the store");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !stat_o.cnt_full)
    else $error("insert into a full store");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> !stat_o.cnt_zero)
    else $error("remove from an empty store");

endmodule

// File: rtl/core/unique_value_deque_top.sv
`timescale 1ns / 1ps

// Ordered set of distinct signed 32-bit values, at most CAPACITY of them,
// kept as a circular list in a single-port-read, single-port-write memory.
// An operation is taken when start_i is high and busy_o is low; each result
// beat is on the result ports for exactly one cycle, marked by
// result_valid_o, and must be taken then, since the block cannot be held
// off. Timing is set by the walk through the memory, one list position per
// cycle: with N stored values, search, remove by value and the duplicate
// check of an insert walk up to N positions (a removal from the middle
// adds the gap close), remove head or tail reads the end value and then
// answers, read out gives its N beats back to back, and a remove, search
// or read out on an empty store or an unused mode answers straight from
// idle. No clearing pass is needed after reset.
module unique_value_deque_top #(
  parameter int unsigned CAPACITY = uvd_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [uvd_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [uvd_pkg::VALUE_W-1:0] value_i,
  output logic                               result_valid_o,
  output logic [uvd_pkg::STATUS_W-1:0]       status_o,
  output logic signed [uvd_pkg::VALUE_W-1:0] element_o,
  output logic [uvd_pkg::COUNT_W-1:0]        count_o,
  output logic                               last_o
);

  uvd_pkg::dp_cmd_t  cmd;
  uvd_pkg::dp_stat_t stat;

  uvd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  uvd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .element_o      (element_o),
    .count_o        (count_o),
    .last_o         (last_o)
  );

endmodule
